// ===== rtl/core/rvx_pkg.sv =====
package rvx_pkg;

   // Data memory geometry: four byte banks, one row holds one aligned word.
   localparam int unsigned MEM_BYTES    = 65536;
   localparam int unsigned NUM_BANKS    = 4;
   localparam int unsigned MEM_ROWS     = MEM_BYTES / NUM_BANKS;
   localparam int unsigned MEM_ROW_BITS = $clog2(MEM_ROWS);

   localparam int unsigned NUM_REGS = 32;
   localparam int unsigned REG_BITS = 5;

   // Response queue: also bounds the number of requests in flight.
   localparam int unsigned RSP_QUEUE_DEPTH = 4;
   localparam int unsigned RSP_PTR_BITS    = $clog2(RSP_QUEUE_DEPTH);
   localparam int unsigned RSP_CNT_BITS    = $clog2(RSP_QUEUE_DEPTH + 1);

   localparam logic [31:0] WORD_BYTES = 32'd4;
   localparam logic [31:0] JALR_MASK  = ~32'b1;

   localparam logic [5:0] OP_ADD    = 6'd0;
   localparam logic [5:0] OP_ADDI   = 6'd1;
   localparam logic [5:0] OP_AND    = 6'd2;
   localparam logic [5:0] OP_ANDI   = 6'd3;
   localparam logic [5:0] OP_OR     = 6'd4;
   localparam logic [5:0] OP_ORI    = 6'd5;
   localparam logic [5:0] OP_XOR    = 6'd6;
   localparam logic [5:0] OP_XORI   = 6'd7;
   localparam logic [5:0] OP_SLL    = 6'd8;
   localparam logic [5:0] OP_SLLI   = 6'd9;
   localparam logic [5:0] OP_SRA    = 6'd10;
   localparam logic [5:0] OP_SRAI   = 6'd11;
   localparam logic [5:0] OP_SRL    = 6'd12;
   localparam logic [5:0] OP_SRLI   = 6'd13;
   localparam logic [5:0] OP_SUB    = 6'd14;
   localparam logic [5:0] OP_SLT    = 6'd15;
   localparam logic [5:0] OP_SLTU   = 6'd16;
   localparam logic [5:0] OP_SLTI   = 6'd17;
   localparam logic [5:0] OP_SLTIU  = 6'd18;
   localparam logic [5:0] OP_BEQ    = 6'd19;
   localparam logic [5:0] OP_BNE    = 6'd20;
   localparam logic [5:0] OP_BLT    = 6'd21;
   localparam logic [5:0] OP_BGE    = 6'd22;
   localparam logic [5:0] OP_BLTU   = 6'd23;
   localparam logic [5:0] OP_BGEU   = 6'd24;
   localparam logic [5:0] OP_LW     = 6'd25;
   localparam logic [5:0] OP_LH     = 6'd26;
   localparam logic [5:0] OP_LHU    = 6'd27;
   localparam logic [5:0] OP_LB     = 6'd28;
   localparam logic [5:0] OP_LBU    = 6'd29;
   localparam logic [5:0] OP_SW     = 6'd30;
   localparam logic [5:0] OP_SH     = 6'd31;
   localparam logic [5:0] OP_SB     = 6'd32;
   localparam logic [5:0] OP_JAL    = 6'd33;
   localparam logic [5:0] OP_JALR   = 6'd34;
   localparam logic [5:0] OP_LUI    = 6'd35;
   localparam logic [5:0] OP_AUIPC  = 6'd36;
   localparam logic [5:0] OP_ECALL  = 6'd37;
   localparam logic [5:0] OP_FENCE  = 6'd38;
   localparam logic [5:0] OP_EBREAK = 6'd39;
   localparam logic [5:0] OP_PAUSE  = 6'd40;
   localparam logic [5:0] OP_SBREAK = 6'd41;
   localparam logic [5:0] OP_SCALL  = 6'd42;

   // Access sizes.
   localparam logic [1:0] SIZE_BYTE = 2'd0;
   localparam logic [1:0] SIZE_HALF = 2'd1;
   localparam logic [1:0] SIZE_WORD = 2'd2;

   typedef struct packed {
      logic [5:0]         op;
      logic [4:0]         dest_reg;
      logic [4:0]         src_reg_a;
      logic [4:0]         src_reg_b;
      logic signed [31:0] immediate;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic        reg_written;
      logic [4:0]  written_reg;
      logic [31:0] written_value;
      logic        system_call;
      logic        bad_opcode;
   } rsp_type;

   typedef struct packed {
      logic [31:0] result;
      logic        wr;
      logic [31:0] next_pc;
      logic        sys;
      logic        bad;
      logic        mem_rd;
      logic        mem_wr;
      logic [1:0]  mem_size;
      logic        mem_signed;
      logic [31:0] addr;
   } exec_type;

   typedef struct packed {
      logic                    we;
      logic [MEM_ROW_BITS-1:0] row;
      logic [7:0]              wdata;
   } mem_lane_type;

endpackage

// ===== rtl/core/rv32i_execute_unit_core.sv =====
// Throughput: one request per cycle while req_ready is high; every stage advances
//   each cycle, and the four-entry response queue bounds the requests in flight
//   when rsp_ready is low.
// Reset clears control and then sweeps the data memory and register file to zero,
//   one row per cycle over all MEM_BYTES/4 = 16384 rows, with req_ready held low.
module rv32i_execute_unit_core
   import rvx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // Writeback stage payload.
   typedef struct packed {
      logic [31:0] next_pc;
      logic        wr;
      logic [4:0]  rd;
      logic [31:0] result;
      logic        is_load;
      logic [1:0]  size;
      logic        sext;
      logic [1:0]  offset;
      logic        sys;
      logic        bad;
   } wb_type;

   // ------------------------------------------------------------------
   // Reset clearing sweep
   // ------------------------------------------------------------------
   logic                    clr_active_ff, clr_active_in;
   logic [MEM_ROW_BITS-1:0] clr_row_ff, clr_row_in;

   always_comb begin
      clr_active_in = clr_active_ff;
      clr_row_in    = clr_row_ff;
      if (clr_active_ff) begin
         clr_row_in = clr_row_ff + 1'b1;
         // Drop out of the sweep after the last row.
         if (clr_row_ff == MEM_ROW_BITS'(MEM_ROWS - 1)) begin
            clr_active_in = 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------
   // Admission: stage valids plus queued responses never exceed the queue
   // ------------------------------------------------------------------
   logic                    e_valid_ff;
   logic                    w_valid_ff;
   logic [RSP_CNT_BITS-1:0] queue_count;
   logic [RSP_CNT_BITS:0]   inflight;
   logic                    req_fire;

   assign inflight = {1'b0, queue_count} + (RSP_CNT_BITS + 1)'(e_valid_ff)
                   + (RSP_CNT_BITS + 1)'(w_valid_ff);
   assign req_ready = !clr_active_ff && (inflight < (RSP_CNT_BITS + 1)'(RSP_QUEUE_DEPTH));
   assign req_fire  = req_valid && req_ready;

   // ------------------------------------------------------------------
   // Register file: two copies, one per read port, written together.
   // Read is issued with the request, data arrives in the execute stage.
   // ------------------------------------------------------------------
   logic                rf_we;
   logic [REG_BITS-1:0] rf_waddr;
   logic [31:0]         rf_wdata;
   logic [31:0]         rf_rd_a;
   logic [31:0]         rf_rd_b;
   logic                w_we;
   logic [31:0]         w_value;
   wb_type              w_ff, w_in;

   always_comb begin
      if (clr_active_ff) begin
         // Zero the first rows' worth of registers during the sweep.
         rf_we    = (clr_row_ff[MEM_ROW_BITS-1:REG_BITS] == '0);
         rf_waddr = clr_row_ff[REG_BITS-1:0];
         rf_wdata = '0;
      end else begin
         rf_we    = w_we;
         rf_waddr = w_ff.rd;
         rf_wdata = w_value;
      end
   end

   rvx_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_a (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (req_data.src_reg_a),
      .rd_data (rf_rd_a)
   );

   rvx_ram #(.WIDTH(32), .DEPTH(NUM_REGS)) u_rf_b (
      .clock   (clock),
      .wr_en   (rf_we),
      .wr_addr (rf_waddr),
      .wr_data (rf_wdata),
      .rd_addr (req_data.src_reg_b),
      .rd_data (rf_rd_b)
   );

   // ------------------------------------------------------------------
   // Execute stage
   // ------------------------------------------------------------------
   req_type     e_req_ff;
   logic [31:0] pc_ff, pc_in;
   logic        byp_valid_ff;
   logic [4:0]  byp_reg_ff;
   logic [31:0] byp_value_ff;
   logic [31:0] opnd_a;
   logic [31:0] opnd_b;
   exec_type    ex;

   // Forward from the writeback stage first, then from the write that landed
   // at the same edge as the register file read.
   always_comb begin
      if (w_we && (w_ff.rd == e_req_ff.src_reg_a)) begin
         opnd_a = w_value;
      end else if (byp_valid_ff && (byp_reg_ff == e_req_ff.src_reg_a)) begin
         opnd_a = byp_value_ff;
      end else begin
         opnd_a = rf_rd_a;
      end
      if (w_we && (w_ff.rd == e_req_ff.src_reg_b)) begin
         opnd_b = w_value;
      end else if (byp_valid_ff && (byp_reg_ff == e_req_ff.src_reg_b)) begin
         opnd_b = byp_value_ff;
      end else begin
         opnd_b = rf_rd_b;
      end
   end

   rvx_exec u_exec (
      .op  (e_req_ff.op),
      .imm (e_req_ff.immediate),
      .a   (opnd_a),
      .b   (opnd_b),
      .pc  (pc_ff),
      .ex  (ex)
   );

   // Advance the PC as the instruction leaves execute.
   assign pc_in = e_valid_ff ? ex.next_pc : pc_ff;

   // ------------------------------------------------------------------
   // Data memory: four byte banks, accessed from execute, data in writeback
   // ------------------------------------------------------------------
   mem_lane_type [NUM_BANKS-1:0] lane;
   logic [NUM_BANKS-1:0][7:0]    bank_rdata;
   logic [31:0]                  ld_value;

   rvx_lsu u_lsu (
      .st_addr   (ex.addr),
      .st_size   (ex.mem_size),
      .st_en     (e_valid_ff && ex.mem_wr),
      .st_data   (opnd_b),
      .lane      (lane),
      .ld_offset (w_ff.offset),
      .ld_size   (w_ff.size),
      .ld_signed (w_ff.sext),
      .ld_bytes  (bank_rdata),
      .ld_value  (ld_value)
   );

   for (genvar j = 0; j < NUM_BANKS; j++) begin : g_bank
      rvx_ram #(.WIDTH(8), .DEPTH(MEM_ROWS)) u_bank (
         .clock   (clock),
         .wr_en   (clr_active_ff || lane[j].we),
         .wr_addr (clr_active_ff ? clr_row_ff : lane[j].row),
         .wr_data (clr_active_ff ? 8'h00 : lane[j].wdata),
         .rd_addr (lane[j].row),
         .rd_data (bank_rdata[j])
      );
   end

   // ------------------------------------------------------------------
   // Writeback stage
   // ------------------------------------------------------------------
   always_comb begin
      w_in.next_pc = ex.next_pc;
      w_in.wr      = ex.wr && (e_req_ff.dest_reg != '0);
      w_in.rd      = e_req_ff.dest_reg;
      w_in.result  = ex.result;
      w_in.is_load = ex.mem_rd;
      w_in.size    = ex.mem_size;
      w_in.sext    = ex.mem_signed;
      w_in.offset  = ex.addr[1:0];
      w_in.sys     = ex.sys;
      w_in.bad     = ex.bad;
   end

   assign w_value = w_ff.is_load ? ld_value : w_ff.result;
   assign w_we    = w_valid_ff && w_ff.wr;

   rsp_type w_rsp;

   always_comb begin
      w_rsp.next_pc       = w_ff.next_pc;
      w_rsp.reg_written   = w_ff.wr;
      w_rsp.written_reg   = w_ff.wr ? w_ff.rd : '0;
      w_rsp.written_value = w_ff.wr ? w_value : '0;
      w_rsp.system_call   = w_ff.sys;
      w_rsp.bad_opcode    = w_ff.bad;
   end

   rvx_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (w_valid_ff),
      .push_data (w_rsp),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data),
      .count     (queue_count)
   );

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_active_ff <= 1'b1;
         clr_row_ff    <= '0;
         e_valid_ff    <= 1'b0;
         w_valid_ff    <= 1'b0;
         byp_valid_ff  <= 1'b0;
         pc_ff         <= '0;
      end else begin
         clr_active_ff <= clr_active_in;
         clr_row_ff    <= clr_row_in;
         e_valid_ff    <= req_fire;
         w_valid_ff    <= e_valid_ff;
         byp_valid_ff  <= w_we;
         pc_ff         <= pc_in;
      end
   end

   // Payload: no reset needed.
   always_ff @(posedge clock) begin
      e_req_ff     <= req_data;
      w_ff         <= w_in;
      byp_reg_ff   <= w_ff.rd;
      byp_value_ff <= w_value;
   end

endmodule

// ===== rtl/core/rvx_ram.sv =====
module rvx_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 1024,
   localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when the same entry is written.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rvx_exec.sv =====
module rvx_exec
   import rvx_pkg::*;
(
   input  logic [5:0]  op,
   input  logic [31:0] imm,
   input  logic [31:0] a,
   input  logic [31:0] b,
   input  logic [31:0] pc,
   output exec_type    ex
);

   logic [31:0] pc4;
   logic [31:0] pc_imm;
   logic [31:0] sum_ai;
   logic        taken;

   assign pc4    = pc + WORD_BYTES;
   assign pc_imm = pc + imm;
   assign sum_ai = a + imm;

   always_comb begin
      ex         = '0;
      ex.next_pc = pc4;
      ex.addr    = sum_ai;
      taken      = 1'b0;
      case (op)
         OP_ADD:   begin ex.result = a + b;  ex.wr = 1'b1; end
         OP_ADDI:  begin ex.result = sum_ai; ex.wr = 1'b1; end
         OP_AND:   begin ex.result = a & b;  ex.wr = 1'b1; end
         OP_ANDI:  begin ex.result = a & imm; ex.wr = 1'b1; end
         OP_OR:    begin ex.result = a | b;  ex.wr = 1'b1; end
         OP_ORI:   begin ex.result = a | imm; ex.wr = 1'b1; end
         OP_XOR:   begin ex.result = a ^ b;  ex.wr = 1'b1; end
         OP_XORI:  begin ex.result = a ^ imm; ex.wr = 1'b1; end
         OP_SLL:   begin ex.result = a << b[4:0];   ex.wr = 1'b1; end
         OP_SLLI:  begin ex.result = a << imm[4:0]; ex.wr = 1'b1; end
         OP_SRA:   begin ex.result = 32'($signed(a) >>> b[4:0]);   ex.wr = 1'b1; end
         OP_SRAI:  begin ex.result = 32'($signed(a) >>> imm[4:0]); ex.wr = 1'b1; end
         OP_SRL:   begin ex.result = a >> b[4:0];   ex.wr = 1'b1; end
         OP_SRLI:  begin ex.result = a >> imm[4:0]; ex.wr = 1'b1; end
         OP_SUB:   begin ex.result = a - b; ex.wr = 1'b1; end
         OP_SLT:   begin ex.result = {31'b0, $signed(a) < $signed(b)};   ex.wr = 1'b1; end
         OP_SLTU:  begin ex.result = {31'b0, a < b};                     ex.wr = 1'b1; end
         OP_SLTI:  begin ex.result = {31'b0, $signed(a) < $signed(imm)}; ex.wr = 1'b1; end
         OP_SLTIU: begin ex.result = {31'b0, a < imm};                   ex.wr = 1'b1; end
         OP_BEQ:   taken = (a == b);
         OP_BNE:   taken = (a != b);
         OP_BLT:   taken = ($signed(a) < $signed(b));
         OP_BGE:   taken = !($signed(a) < $signed(b));
         OP_BLTU:  taken = (a < b);
         OP_BGEU:  taken = (a >= b);
         OP_LW:    begin ex.mem_rd = 1'b1; ex.wr = 1'b1; ex.mem_size = SIZE_WORD; end
         OP_LH:    begin
            ex.mem_rd = 1'b1; ex.wr = 1'b1; ex.mem_size = SIZE_HALF; ex.mem_signed = 1'b1;
         end
         OP_LHU:   begin ex.mem_rd = 1'b1; ex.wr = 1'b1; ex.mem_size = SIZE_HALF; end
         OP_LB:    begin
            ex.mem_rd = 1'b1; ex.wr = 1'b1; ex.mem_size = SIZE_BYTE; ex.mem_signed = 1'b1;
         end
         OP_LBU:   begin ex.mem_rd = 1'b1; ex.wr = 1'b1; ex.mem_size = SIZE_BYTE; end
         OP_SW:    begin ex.mem_wr = 1'b1; ex.mem_size = SIZE_WORD; end
         OP_SH:    begin ex.mem_wr = 1'b1; ex.mem_size = SIZE_HALF; end
         OP_SB:    begin ex.mem_wr = 1'b1; ex.mem_size = SIZE_BYTE; end
         OP_JAL:   begin ex.result = pc4; ex.wr = 1'b1; ex.next_pc = pc_imm; end
         OP_JALR:  begin ex.result = pc4; ex.wr = 1'b1; ex.next_pc = sum_ai & JALR_MASK; end
         OP_LUI:   begin ex.result = imm;    ex.wr = 1'b1; end
         OP_AUIPC: begin ex.result = pc_imm; ex.wr = 1'b1; end
         OP_ECALL: ex.sys = 1'b1;
         OP_FENCE, OP_EBREAK, OP_PAUSE, OP_SBREAK, OP_SCALL: ;
         default: begin
            // Unknown opcode: hold the PC, change nothing.
            ex.bad     = 1'b1;
            ex.next_pc = pc;
         end
      endcase
      if (taken) begin
         ex.next_pc = pc_imm;
      end
   end

endmodule

// ===== rtl/core/rvx_lsu.sv =====
module rvx_lsu
   import rvx_pkg::*;
(
   input  logic [31:0]                   st_addr,
   input  logic [1:0]                    st_size,
   input  logic                          st_en,
   input  logic [31:0]                   st_data,
   output mem_lane_type [NUM_BANKS-1:0]  lane,
   input  logic [1:0]                    ld_offset,
   input  logic [1:0]                    ld_size,
   input  logic                          ld_signed,
   input  logic [NUM_BANKS-1:0][7:0]     ld_bytes,
   output logic [31:0]                   ld_value
);

   // Bank j holds byte k = (j - offset) mod 4 of the access; banks below the
   // offset take the next row.
   always_comb begin
      logic [1:0] k;
      logic       in_range;
      for (int j = 0; j < NUM_BANKS; j++) begin
         k = 2'(j) - st_addr[1:0];
         case (st_size)
            SIZE_BYTE: in_range = (k == 2'd0);
            SIZE_HALF: in_range = !k[1];
            SIZE_WORD: in_range = 1'b1;
            default:   in_range = 1'b0;
         endcase
         lane[j].we    = st_en && in_range;
         lane[j].row   = st_addr[MEM_ROW_BITS+1:2] + MEM_ROW_BITS'(2'(j) < st_addr[1:0]);
         lane[j].wdata = 8'(st_data >> {k, 3'b000});
      end
   end

   // Rotate the bank bytes back into access order, then extend.
   always_comb begin
      logic [31:0] raw;
      for (int k = 0; k < NUM_BANKS; k++) begin
         raw[8*k +: 8] = ld_bytes[2'(k) + ld_offset];
      end
      case (ld_size)
         SIZE_BYTE: ld_value = {{24{ld_signed & raw[7]}}, raw[7:0]};
         SIZE_HALF: ld_value = {{16{ld_signed & raw[15]}}, raw[15:0]};
         SIZE_WORD: ld_value = raw;
         default:   ld_value = raw;
      endcase
   end

endmodule

// ===== rtl/core/rvx_rsp_queue.sv =====
module rvx_rsp_queue
   import rvx_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  rsp_type                 push_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output rsp_type                 out_data,
   output logic [RSP_CNT_BITS-1:0] count
);

   rsp_type                 entries_ff [RSP_QUEUE_DEPTH];
   logic [RSP_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_BITS-1:0] count_ff, count_in;
   logic                    pop;

   assign out_valid = (count_ff != '0);
   assign out_data  = entries_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_BITS'(push) - RSP_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/rvx_checker.sv =====
module rvx_checker
   import rvx_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // The clearing sweep starts right after reset: nothing taken, nothing shown.
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("request taken or response shown right after reset");

   a_bad_no_effect: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_opcode |->
         !rsp_data.reg_written && !rsp_data.system_call)
      else $error("bad opcode response reports a write or a system call");

   a_no_x0_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reg_written |-> rsp_data.written_reg != 5'd0)
      else $error("response reports a write to x0");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.reg_written |->
         rsp_data.written_reg == 5'd0 && rsp_data.written_value == 32'd0)
      else $error("write-back fields not zero without a write");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response dropped or changed");

endmodule

bind rv32i_execute_unit_core rvx_checker u_rvx_checker (.*);

// ===== tb/sv/rv32i_execute_unit_checker.sv =====
`timescale 1ns / 1ps

module rv32i_execute_unit_checker
   import rvx_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      outstanding,
   output int      compared
);

   localparam int REPORT_LIMIT = 10;

   // Architectural state as the core should see it.
   logic [31:0] arch_gpr [NUM_REGS];
   logic [31:0] arch_pc;
   logic [7:0]  arch_mem [MEM_BYTES];
   logic [63:0] instret;

   // Predicted retirements, oldest first.
   rsp_type retire_q [$];

   int fails = 0;
   int matched = 0;

   initial begin
      fail_count  = 0;
      outstanding = 0;
      compared    = 0;
   end

   function automatic logic [31:0] mem_read(input logic [31:0] addr, input int nbytes);
      logic [31:0] v;
      logic [31:0] loc;
      int k;
      v = '0;
      for (k = 0; k < nbytes; k++) begin
         loc = (addr + 32'(k)) % MEM_BYTES;
         v   = v | (32'(arch_mem[loc]) << (8 * k));
      end
      return v;
   endfunction

   function automatic void mem_write(input logic [31:0] addr, input logic [31:0] v,
                                     input int nbytes);
      logic [31:0] loc;
      int k;
      for (k = 0; k < nbytes; k++) begin
         loc = (addr + 32'(k)) % MEM_BYTES;
         arch_mem[loc] = v[8*k +: 8];
      end
   endfunction

   // Retire one instruction against the architectural state.
   function automatic rsp_type execute_instr(input req_type r);
      rsp_type     e;
      logic [31:0] a, b, imm, pc, nxt, res, addr;
      logic        wr, sys, taken;
      a     = (r.src_reg_a == '0) ? '0 : arch_gpr[r.src_reg_a];
      b     = (r.src_reg_b == '0) ? '0 : arch_gpr[r.src_reg_b];
      imm   = r.immediate;
      pc    = arch_pc;
      nxt   = pc + WORD_BYTES;
      res   = '0;
      addr  = a + imm;
      wr    = 1'b0;
      sys   = 1'b0;
      taken = 1'b0;
      e     = '0;

      // Unsupported opcode: flag it, leave all state alone.
      if (r.op > OP_SCALL) begin
         e.next_pc    = pc;
         e.bad_opcode = 1'b1;
         return e;
      end

      case (r.op)
         OP_ADD:    begin res = a + b; wr = 1'b1; end
         OP_ADDI:   begin res = a + imm; wr = 1'b1; end
         OP_AND:    begin res = a & b; wr = 1'b1; end
         OP_ANDI:   begin res = a & imm; wr = 1'b1; end
         OP_OR:     begin res = a | b; wr = 1'b1; end
         OP_ORI:    begin res = a | imm; wr = 1'b1; end
         OP_XOR:    begin res = a ^ b; wr = 1'b1; end
         OP_XORI:   begin res = a ^ imm; wr = 1'b1; end
         OP_SLL:    begin res = a << b[4:0]; wr = 1'b1; end
         OP_SLLI:   begin res = a << imm[4:0]; wr = 1'b1; end
         OP_SRA:    begin res = $signed(a) >>> b[4:0]; wr = 1'b1; end
         OP_SRAI:   begin res = $signed(a) >>> imm[4:0]; wr = 1'b1; end
         OP_SRL:    begin res = a >> b[4:0]; wr = 1'b1; end
         OP_SRLI:   begin res = a >> imm[4:0]; wr = 1'b1; end
         OP_SUB:    begin res = a - b; wr = 1'b1; end
         OP_SLT:    begin res = 32'($signed(a) < $signed(b)); wr = 1'b1; end
         OP_SLTU:   begin res = 32'(a < b); wr = 1'b1; end
         OP_SLTI:   begin res = 32'($signed(a) < $signed(imm)); wr = 1'b1; end
         OP_SLTIU:  begin res = 32'(a < imm); wr = 1'b1; end
         OP_BEQ:    taken = (a == b);
         OP_BNE:    taken = (a != b);
         OP_BLT:    taken = ($signed(a) < $signed(b));
         OP_BGE:    taken = ($signed(a) >= $signed(b));
         OP_BLTU:   taken = (a < b);
         OP_BGEU:   taken = (a >= b);
         OP_LW:     begin res = mem_read(addr, 4); wr = 1'b1; end
         OP_LH:     begin
            res = mem_read(addr, 2);
            res = {{16{res[15]}}, res[15:0]};
            wr  = 1'b1;
         end
         OP_LHU:    begin res = mem_read(addr, 2); wr = 1'b1; end
         OP_LB:     begin
            res = mem_read(addr, 1);
            res = {{24{res[7]}}, res[7:0]};
            wr  = 1'b1;
         end
         OP_LBU:    begin res = mem_read(addr, 1); wr = 1'b1; end
         OP_SW:     mem_write(addr, b, 4);
         OP_SH:     mem_write(addr, b, 2);
         OP_SB:     mem_write(addr, b, 1);
         OP_JAL:    begin res = pc + WORD_BYTES; wr = 1'b1; nxt = pc + imm; end
         OP_JALR:   begin res = pc + WORD_BYTES; wr = 1'b1; nxt = addr & JALR_MASK; end
         OP_LUI:    begin res = imm; wr = 1'b1; end
         OP_AUIPC:  begin res = pc + imm; wr = 1'b1; end
         OP_ECALL:  sys = 1'b1;
         default:   ;
      endcase

      if (taken) nxt = pc + imm;

      wr = wr && (r.dest_reg != '0);
      if (wr) arch_gpr[r.dest_reg] = res;
      arch_pc = nxt;
      instret = instret + 64'd1;

      e.next_pc       = nxt;
      e.reg_written   = wr;
      e.written_reg   = wr ? r.dest_reg : '0;
      e.written_value = wr ? res : '0;
      e.system_call   = sys;
      e.bad_opcode    = 1'b0;
      return e;
   endfunction

   always @(posedge clock) begin : track
      rsp_type want;
      int i;
      if (reset) begin
         for (i = 0; i < NUM_REGS; i++) arch_gpr[i] = '0;
         for (i = 0; i < MEM_BYTES; i++) arch_mem[i] = '0;
         arch_pc = '0;
         instret = '0;
         retire_q.delete();
      end else begin
         if (req_valid && req_ready) retire_q.push_back(execute_instr(req_data));
         if (rsp_valid && rsp_ready) begin
            if (retire_q.size() == 0) begin
               fails++;
               if (fails <= REPORT_LIMIT)
                  $display("checker: response with nothing pending at %0t: %h",
                           $realtime, rsp_data);
            end else begin
               want = retire_q.pop_front();
               matched++;
               if (rsp_data.next_pc       !== want.next_pc       ||
                   rsp_data.reg_written   !== want.reg_written   ||
                   rsp_data.written_reg   !== want.written_reg   ||
                   rsp_data.written_value !== want.written_value ||
                   rsp_data.system_call   !== want.system_call   ||
                   rsp_data.bad_opcode    !== want.bad_opcode) begin
                  fails++;
                  if (fails <= REPORT_LIMIT)
                     $display({"checker: mismatch on response %0d (exp/act): pc %h/%h ",
                               "wr %b/%b rd %0d/%0d val %h/%h sys %b/%b bad %b/%b"},
                              matched, want.next_pc, rsp_data.next_pc,
                              want.reg_written, rsp_data.reg_written,
                              want.written_reg, rsp_data.written_reg,
                              want.written_value, rsp_data.written_value,
                              want.system_call, rsp_data.system_call,
                              want.bad_opcode, rsp_data.bad_opcode);
               end
            end
         end
      end
      fail_count  <= fails;
      outstanding <= retire_q.size();
      compared    <= matched;
   end

endmodule

// ===== tb/sv/rv32i_execute_unit_core_test.sv =====
`timescale 1ns / 1ps

module rv32i_execute_unit_core_test;
   import rvx_pkg::*;

   // Part goes to the reset sweep over MEM_BYTES/4 rows; the rest covers worst-case
   // gaps and stalls on every request several times over.
   localparam int CYCLE_LIMIT    = 600000;
   localparam int RANDOM_TARGET  = 1050;
   localparam int DRAIN_CYCLES   = 12;
   localparam logic [5:0] BAD_OP_FIRST = OP_SCALL + 6'd1;
   localparam logic [5:0] OP_CODE_MAX  = 6'h3F;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int outstanding;
   int compared;

   int cycle_count = 0;
   int n_sent = 0;
   int n_alu = 0, n_branch = 0, n_mem = 0, n_jump = 0, n_sys = 0, n_bad = 0;

   // While set, both sides run flat out with no idle cycles.
   logic burst = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rv32i_execute_unit_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   rv32i_execute_unit_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .compared    (compared)
   );

   // Mostly short gaps, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Mix of boundary values, small signed offsets and full-range noise.
   function automatic logic [31:0] pick_imm();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) begin
         case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            default: return 32'hFFFF_FFFF;
         endcase
      end
      if (r < 5) return 32'($urandom_range(0, 4095)) - 32'd2048;
      return $urandom();
   endfunction

   // Offsets off x0 that land in a small window at the bottom of memory, or just
   // below the 2^32 boundary so the access wraps; keeps loads hitting stored data.
   function automatic logic [31:0] window_imm();
      return 32'($urandom_range(0, 143)) - 32'd16;
   endfunction

   // Present one request and hold it until the core takes it.
   task automatic issue(input logic [5:0] op, input logic [4:0] rd, input logic [4:0] ra,
                        input logic [4:0] rb, input logic [31:0] imm);
      req_type item;
      int gap;
      item.op        = op;
      item.dest_reg  = rd;
      item.src_reg_a = ra;
      item.src_reg_b = rb;
      item.immediate = imm;
      gap = burst ? 0 : pick_gap();
      // Drop valid only when a gap is wanted; back-to-back requests keep it high.
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      n_sent++;
      if (op <= OP_SLTIU) n_alu++;
      else if (op <= OP_BGEU) n_branch++;
      else if (op <= OP_SB) n_mem++;
      else if (op <= OP_AUIPC) n_jump++;
      else if (op <= OP_SCALL) n_sys++;
      else n_bad++;
   endtask

   // Response side: stall for random stretches, hold ready high during bursts.
   initial begin : rsp_side
      int hold;
      forever begin
         hold = burst ? 0 : pick_gap();
         if (hold != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
   end

   // Watchdog: a lost or stuck response ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   initial begin : stimulus
      logic [5:0]  op;
      logic [4:0]  rd, ra, rb;
      logic [31:0] imm;
      int kind;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: seed registers with extreme values, then walk the corner cases.
      issue(OP_LUI,   5'd1,  5'd0,  5'd0,  32'h8000_0000);
      issue(OP_ADDI,  5'd2,  5'd0,  5'd0,  32'hFFFF_FFFF);
      issue(OP_ADDI,  5'd3,  5'd0,  5'd0,  32'h7FFF_FFFF);
      issue(OP_ADD,   5'd4,  5'd1,  5'd2,  32'h0);          // signed overflow wraps
      issue(OP_SRA,   5'd6,  5'd1,  5'd2,  32'h0);          // shift by low 5 bits = 31
      issue(OP_SRLI,  5'd7,  5'd1,  5'd0,  32'hFFFF_FFE1);  // upper immediate bits ignored
      issue(OP_SLT,   5'd9,  5'd1,  5'd3,  32'h0);
      issue(OP_ADD,   5'd0,  5'd1,  5'd2,  32'h0);          // write to x0 is discarded
      issue(OP_ADD,   5'd12, 5'd0,  5'd0,  32'h0);          // x0 still reads zero
      issue(OP_SW,    5'd0,  5'd0,  5'd2,  32'hFFFF_FFFE);  // store wraps past top of memory
      issue(OP_LW,    5'd13, 5'd0,  5'd0,  32'hFFFF_FFFE);
      issue(OP_SW,    5'd0,  5'd0,  5'd1,  32'd5);          // unaligned word store
      issue(OP_LH,    5'd14, 5'd0,  5'd0,  32'd7);          // sign-extended half
      issue(OP_LB,    5'd16, 5'd0,  5'd0,  32'd8);          // sign-extended byte
      issue(OP_BEQ,   5'd0,  5'd0,  5'd0,  32'hFFFF_FFF8);  // taken backward
      issue(OP_BNE,   5'd0,  5'd1,  5'd1,  32'd64);         // not taken
      issue(OP_BLT,   5'd0,  5'd1,  5'd3,  32'h7FFF_FFFC);
      issue(OP_JAL,   5'd18, 5'd0,  5'd0,  32'h7FFF_FFFC);
      issue(OP_JALR,  5'd19, 5'd2,  5'd0,  32'h0);          // target bit 0 cleared
      issue(OP_JALR,  5'd19, 5'd19, 5'd0,  32'd4);          // link overwrites its own base
      issue(OP_AUIPC, 5'd21, 5'd0,  5'd0,  32'h1234_5000);
      issue(OP_ECALL, 5'd5,  5'd0,  5'd0,  32'h0);
      issue(OP_FENCE, 5'd5,  5'd1,  5'd2,  32'hFFFF_FFFF);
      issue(BAD_OP_FIRST, 5'd8, 5'd1, 5'd2, 32'h0);         // lowest unsupported opcode
      issue(OP_CODE_MAX,  5'd8, 5'd1, 5'd2, 32'hFFFF_FFFF);

      // Random part: mostly register traffic and store/load pairs over a small
      // window, with branches, jumps, system ops and unsupported opcodes mixed in.
      while (n_sent < RANDOM_TARGET) begin
         if (n_sent % 64 == 0) burst = ($urandom_range(0, 4) == 0);
         kind = $urandom_range(0, 19);
         rd   = 5'($urandom_range(0, 31));
         ra   = 5'($urandom_range(0, 31));
         rb   = 5'($urandom_range(0, 31));
         imm  = pick_imm();
         if (kind <= 8) begin
            op = 6'($urandom_range(OP_ADD, OP_SLTIU));
            issue(op, rd, ra, rb, imm);
         end else if (kind <= 10) begin
            // Make equal operands common so both branch outcomes show up.
            if ($urandom_range(0, 2) == 0) rb = ra;
            op = 6'($urandom_range(OP_BEQ, OP_BGEU));
            issue(op, rd, ra, rb, imm);
         end else if (kind <= 13) begin
            // Store then load back through the same address.
            if ($urandom_range(0, 3) != 0) begin
               ra  = '0;
               imm = window_imm();
            end
            op = 6'($urandom_range(OP_SW, OP_SB));
            issue(op, rd, ra, rb, imm);
            op = 6'($urandom_range(OP_LW, OP_LBU));
            issue(op, rd, ra, 5'($urandom_range(0, 31)), imm);
         end else if (kind <= 15) begin
            if ($urandom_range(0, 2) != 0) begin
               ra  = '0;
               imm = window_imm();
            end
            op = 6'($urandom_range(OP_LW, OP_SB));
            issue(op, rd, ra, rb, imm);
         end else if (kind <= 17) begin
            op = 6'($urandom_range(OP_JAL, OP_AUIPC));
            issue(op, rd, ra, rb, imm);
         end else if (kind == 18) begin
            op = 6'($urandom_range(OP_ECALL, OP_SCALL));
            issue(op, rd, ra, rb, imm);
         end else begin
            op = 6'($urandom_range(BAD_OP_FIRST, OP_CODE_MAX));
            issue(op, rd, ra, rb, imm);
         end
      end

      req_valid <= 1'b0;

      // Drain: let the last request reach the pending count, wait for every
      // predicted response, then watch for strays.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run: %0d requests: %0d alu, %0d branch, %0d load/store, %0d jump/upper,",
               n_sent, n_alu, n_branch, n_mem, n_jump);
      $display("run: %0d system, %0d unsupported; %0d responses compared, %0d mismatches",
               n_sys, n_bad, compared, fail_count);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
